### hdl/bmpse_pkg.sv
// ----------------------------------------------------------------------------
// bmpse_pkg
// Shared constants and types of the BMP LSB stego embedder.
// ----------------------------------------------------------------------------
package bmpse_pkg;

	localparam int unsigned HEADER_BYTES_DEF  = 54;
	localparam int unsigned MAX_EXT_CHARS_DEF = 8;

	localparam int unsigned POS_W       = 40;
	localparam int unsigned WIDTH_OFS   = 18;
	localparam int unsigned HEIGHT_OFS  = 22;
	localparam int unsigned DIM_END     = 26;
	localparam int unsigned MAGIC_BITS  = 16;
	localparam int unsigned FIELD_BITS  = 32;
	localparam int unsigned LEN_END     = MAGIC_BITS + FIELD_BITS;
	localparam int unsigned FRAME_BITS  = MAGIC_BITS + 3 * FIELD_BITS;
	localparam int unsigned NEED_W      = 36;
	localparam int unsigned EXT_CHAR_W  = 64;

	// "#*", first character in the upper byte
	localparam logic [MAGIC_BITS-1:0] MAGIC = 16'h232A;

	typedef enum logic [1:0] {
		ST_BUSY     = 2'd0,
		ST_DONE     = 2'd1,
		ST_CAP_FAIL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_SECRET_SIZE = 2'd0,
		REG_EXT_LENGTH  = 2'd1,
		REG_EXT_CHARS   = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic bit_val;
		logic replace;
		logic take;
		logic last;
	} embed_t;

endpackage

### hdl/bmpse_if.sv
// ----------------------------------------------------------------------------
// bmpse_if
// Valid/ready channels for cover bytes in and stego bytes out.
// ----------------------------------------------------------------------------
interface bmpse_cover_if;
	logic       valid;
	logic       ready;
	logic [7:0] image_byte;
	logic [7:0] secret_byte;
	logic       first_byte;

	modport source(output valid, image_byte, secret_byte, first_byte, input ready);
	modport sink(input valid, image_byte, secret_byte, first_byte, output ready);
endinterface

interface bmpse_stego_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       lsb_replaced;
	logic       take_secret;
	logic [1:0] status;

	modport source(output valid, out_byte, lsb_replaced, take_secret, status, input ready);
	modport sink(input valid, out_byte, lsb_replaced, take_secret, status, output ready);
endinterface

### hdl/bmpse_embed.sv
// ----------------------------------------------------------------------------
// bmpse_embed
// Selects the embedded bit for one payload offset past the header.
// ----------------------------------------------------------------------------
module bmpse_embed (
	input  logic [bmpse_pkg::POS_W-1:0]      offset,
	input  logic [31:0]                      secret_size,
	input  logic [3:0]                       ext_len,
	input  logic [bmpse_pkg::EXT_CHAR_W-1:0] ext_chars,
	input  logic [7:0]                       secret_latch,
	input  logic [7:0]                       secret_byte,
	output bmpse_pkg::embed_t                emb
);

	logic [7:0]                        ext_end;
	logic [7:0]                        size_end;
	logic [bmpse_pkg::NEED_W-1:0]      total;
	logic [bmpse_pkg::NEED_W-1:0]      total_m1;
	logic                              small_ofs;
	logic [7:0]                        d8;
	logic [2:0]                        j;
	logic [2:0]                        ch_idx;
	logic [7:0]                        ch;
	logic [4:0]                        sz_ofs;
	logic [31:0]                       len_word;
	logic [7:0]                        sec;
	logic [bmpse_pkg::MAGIC_BITS-1:0]  magic;

	assign ext_end  = 8'(bmpse_pkg::LEN_END) + {1'b0, ext_len, 3'b000};
	assign size_end = ext_end + 8'(bmpse_pkg::FIELD_BITS);
	assign total    = {1'b0, secret_size, 3'b000} + bmpse_pkg::NEED_W'(size_end);
	assign total_m1 = total - bmpse_pkg::NEED_W'(1);
	assign small_ofs = (offset[bmpse_pkg::POS_W-1:8] == '0);
	assign d8       = offset[7:0];
	assign j        = offset[2:0];
	assign ch_idx   = 3'(d8[7:3] - 5'd6);
	assign ch       = ext_chars[{ch_idx, 3'b000} +: 8];
	assign sz_ofs   = 5'(d8 - ext_end);
	assign len_word = {28'd0, ext_len};
	assign sec      = (j == 3'd0) ? secret_byte : secret_latch;
	assign magic    = bmpse_pkg::MAGIC;

	always_comb begin
		emb         = '0;
		emb.replace = (offset < bmpse_pkg::POS_W'(total));
		emb.last    = (offset == bmpse_pkg::POS_W'(total_m1));
		if (small_ofs && d8 < 8'(bmpse_pkg::MAGIC_BITS)) begin
			emb.bit_val = magic[~d8[3:0]];
		end else if (small_ofs && d8 < 8'(bmpse_pkg::LEN_END)) begin
			emb.bit_val = len_word[5'(6'd47 - d8[5:0])];
		end else if (small_ofs && d8 < ext_end) begin
			emb.bit_val = ch[~j];
		end else if (small_ofs && d8 < size_end) begin
			emb.bit_val = secret_size[~sz_ofs];
		end else begin
			emb.bit_val = sec[~j];
			emb.take    = emb.replace && (j == 3'd0);
		end
	end

endmodule

### hdl/bmp_lsb_stego_embedder_core.sv
// ----------------------------------------------------------------------------
// bmp_lsb_stego_embedder_core
// Passes a BMP stream and hides framed secret data in the pixel byte LSBs.
// ----------------------------------------------------------------------------
// each byte passes the input register and then the result register
// throughput: one byte per cycle while stego.ready does not stall the result
// width*height is built from 32x8 partial products as height bytes arrive
// reset clears config registers, byte position, capacity flag and valids
module bmp_lsb_stego_embedder_core #(
	parameter int unsigned HEADER_BYTES  = bmpse_pkg::HEADER_BYTES_DEF,
	parameter int unsigned MAX_EXT_CHARS = bmpse_pkg::MAX_EXT_CHARS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	bmpse_cover_if.sink                      image_in,
	bmpse_stego_if.source                    stego,
	input  logic                             wr_en,
	input  logic [1:0]                       wr_index,
	input  logic [bmpse_pkg::EXT_CHAR_W-1:0] wr_data
);

	localparam int unsigned NEED_BASE = HEADER_BYTES + bmpse_pkg::FRAME_BITS;
	localparam int unsigned PW        = bmpse_pkg::POS_W;

	logic [31:0]                      secret_size_q;
	logic [3:0]                       ext_length_q;
	logic [bmpse_pkg::EXT_CHAR_W-1:0] ext_chars_q;

	logic          valid_s1;
	logic [7:0]    image_byte_s1;
	logic [7:0]    secret_byte_s1;
	logic          first_byte_s1;

	logic [PW-1:0] pos_q;
	logic [31:0]   width_q;
	logic [31:0]   prod_q;
	logic          cap_fail_q;
	logic [7:0]    latch_q;

	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          replaced_q;
	logic          take_q;
	bmpse_pkg::status_t status_q;

	logic          advance;
	logic [PW-1:0] pos;
	logic [PW-1:0] offset;
	logic          in_hdr;
	logic          at_check;
	logic          in_width;
	logic          in_height;
	logic [1:0]    byte_k;
	logic [31:0]   pp;
	logic [31:0]   pp_sh;
	logic [31:0]   cap;
	logic [bmpse_pkg::NEED_W-1:0] need;
	logic          cap_ok;
	logic          fail;
	logic [3:0]    ext_len;
	bmpse_pkg::embed_t emb;

	logic [7:0]    res_byte;
	logic          res_replaced;
	logic          res_take;
	bmpse_pkg::status_t res_status;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secret_size_q <= '0;
			ext_length_q  <= '0;
			ext_chars_q   <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				bmpse_pkg::REG_SECRET_SIZE: secret_size_q <= wr_data[31:0];
				bmpse_pkg::REG_EXT_LENGTH:  ext_length_q  <= wr_data[3:0];
				bmpse_pkg::REG_EXT_CHARS:   ext_chars_q   <= wr_data;
				default: ;
			endcase
		end
	end

	assign advance        = valid_s1 && (!out_valid_q || stego.ready);
	assign image_in.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (image_in.ready) begin
			valid_s1 <= image_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (image_in.ready && image_in.valid) begin
			image_byte_s1  <= image_in.image_byte;
			secret_byte_s1 <= image_in.secret_byte;
			first_byte_s1  <= image_in.first_byte;
		end
	end

	assign pos       = first_byte_s1 ? '0 : pos_q;
	assign in_hdr    = pos < PW'(HEADER_BYTES);
	assign at_check  = pos == PW'(HEADER_BYTES);
	assign offset    = pos - PW'(HEADER_BYTES);
	assign in_width  = (pos >= PW'(bmpse_pkg::WIDTH_OFS)) && (pos < PW'(bmpse_pkg::HEIGHT_OFS));
	assign in_height = (pos >= PW'(bmpse_pkg::HEIGHT_OFS)) && (pos < PW'(bmpse_pkg::DIM_END));
	assign byte_k    = pos[1:0] - 2'd2;

	// width * height, one height byte at a time
	assign pp    = width_q * {24'd0, image_byte_s1};
	assign pp_sh = pp << {byte_k, 3'b000};

	assign cap    = prod_q + {prod_q[30:0], 1'b0};
	assign need   = bmpse_pkg::NEED_W'(NEED_BASE) + {1'b0, secret_size_q, 3'b000};
	assign cap_ok = {4'd0, cap} > need;
	assign fail   = at_check ? !cap_ok : cap_fail_q;

	assign ext_len = (ext_length_q > 4'(MAX_EXT_CHARS)) ? 4'(MAX_EXT_CHARS) : ext_length_q;

	bmpse_embed u_embed (
		.offset       (offset),
		.secret_size  (secret_size_q),
		.ext_len      (ext_len),
		.ext_chars    (ext_chars_q),
		.secret_latch (latch_q),
		.secret_byte  (secret_byte_s1),
		.emb          (emb)
	);

	always_comb begin
		res_byte     = image_byte_s1;
		res_replaced = 1'b0;
		res_take     = 1'b0;
		res_status   = bmpse_pkg::ST_BUSY;
		if (in_hdr) begin
			res_status = bmpse_pkg::ST_BUSY;
		end else if (fail) begin
			res_status = bmpse_pkg::ST_CAP_FAIL;
		end else if (emb.replace) begin
			res_byte     = {image_byte_s1[7:1], emb.bit_val};
			res_replaced = 1'b1;
			res_take     = emb.take;
			res_status   = emb.last ? bmpse_pkg::ST_DONE : bmpse_pkg::ST_BUSY;
		end else begin
			res_status = bmpse_pkg::ST_DONE;
		end
	end

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			width_q    <= '0;
			prod_q     <= '0;
			cap_fail_q <= 1'b0;
			latch_q    <= '0;
		end else if (advance) begin
			pos_q <= (pos == '1) ? pos : pos + PW'(1);
			if (in_width) begin
				width_q[{byte_k, 3'b000} +: 8] <= image_byte_s1;
			end
			if (in_height) begin
				prod_q <= (byte_k == 2'd0) ? pp_sh : prod_q + pp_sh;
			end
			if (first_byte_s1) begin
				cap_fail_q <= 1'b0;
			end else if (at_check) begin
				cap_fail_q <= !cap_ok;
			end
			if (first_byte_s1) begin
				latch_q <= '0;
			end else if (res_take) begin
				latch_q <= secret_byte_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (stego.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= res_byte;
			replaced_q <= res_replaced;
			take_q     <= res_take;
			status_q   <= res_status;
		end
	end

	assign stego.valid        = out_valid_q;
	assign stego.out_byte     = out_byte_q;
	assign stego.lsb_replaced = replaced_q;
	assign stego.take_secret  = take_q;
	assign stego.status       = status_q;

`ifndef SYNTHESIS
	a_no_embed_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		stego.valid && stego.lsb_replaced |-> stego.status != bmpse_pkg::ST_CAP_FAIL)
		else $error("embedded bit with capacity failure");

	a_take_is_embed: assert property (@(posedge clk) disable iff (!arst_n)
		stego.valid && stego.take_secret |-> stego.lsb_replaced)
		else $error("secret byte taken without embedding");

	a_header_clean: assert property (@(posedge clk) disable iff (!arst_n)
		advance && in_hdr |=> stego.valid && !stego.lsb_replaced
			&& stego.status == bmpse_pkg::ST_BUSY)
		else $error("header byte modified");

	a_fail_latched: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cap_fail_q && !first_byte_s1 && !at_check |=> cap_fail_q)
		else $error("capacity flag dropped mid-stream");
`endif

endmodule
